### hw/rtl/nondominated_front_sort_defines.svh
// Assertion macros shared by the front sort RTL.
`ifndef NONDOMINATED_FRONT_SORT_DEFINES_SVH
`define NONDOMINATED_FRONT_SORT_DEFINES_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define NFS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("front sort check failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define NFS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("front sort check failed");

`endif

### hw/rtl/nfs_pkg.sv
// Types, constants and the dominance compare function of the front sort.
`timescale 1ns / 1ps

package nfs_pkg;

    localparam int MAX_POPULATION = 64;
    localparam int MAX_OBJECTIVES = 4;
    localparam int OBJ_WIDTH      = 32;
    localparam int IDX_W          = $clog2(MAX_POPULATION);
    localparam int CNT_W          = $clog2(MAX_POPULATION + 1);

    localparam logic [1:0] CFG_NUM_OBJECTIVES = 2'd0;
    localparam logic [1:0] CFG_MAXIMIZE_MASK  = 2'd1;
    localparam logic [1:0] CFG_MIN_CLASSIFIED = 2'd2;

    typedef enum logic [1:0] {
        REL_EQUAL,
        REL_A_DOM,
        REL_B_DOM,
        REL_NONE
    } t_rel;

    typedef enum logic [3:0] {
        S_LOAD,
        S_JSTART,
        S_ISSUE,
        S_EVAL,
        S_JEND,
        S_PASSEND,
        S_ORD,
        S_OUT
    } t_state;

    typedef logic [MAX_OBJECTIVES-1:0][OBJ_WIDTH-1:0] t_obj_vec;

    typedef struct packed {
        logic signed [31:0] obj_0;
        logic signed [31:0] obj_1;
        logic signed [31:0] obj_2;
        logic signed [31:0] obj_3;
        logic               last_item;
    } t_in;

    typedef struct packed {
        logic [5:0] individual_index;
        logic [5:0] front_number;
        logic       classified;
        logic [6:0] distinct_in_front0;
        logic       last_result;
    } t_out;

    function automatic t_rel dominance(input t_obj_vec a, input t_obj_vec b,
                                       input logic [2:0] nobj, input logic [3:0] mask);
        logic a_better;
        logic b_better;
        logic a_greater;
        t_rel rel;
        a_better = 1'b0;
        b_better = 1'b0;
        for (int k = 0; k < MAX_OBJECTIVES; k++) begin
            a_greater = $signed(a[k]) > $signed(b[k]);
            if ((k < int'(nobj)) && (a[k] != b[k])) begin
                if (a_greater == mask[k]) begin
                    a_better = 1'b1;
                end else begin
                    b_better = 1'b1;
                end
            end
        end
        if (!a_better && !b_better) begin
            rel = REL_EQUAL;
        end else if (a_better && b_better) begin
            rel = REL_NONE;
        end else if (a_better) begin
            rel = REL_A_DOM;
        end else begin
            rel = REL_B_DOM;
        end
        return rel;
    endfunction

endpackage

### hw/rtl/nondominated_front_sort.sv
// Nondominated front sort: population store, front peeling sequencer and result output.
`timescale 1ns / 1ps
`include "nondominated_front_sort_defines.svh"
// Loading takes one transaction per cycle while o_stall is low; a population of n is
// sorted after its last one. Every sort pass runs one shared dominance comparator over all
// pairs with an unclassified j, each read in S_ISSUE and compared in S_EVAL; passes repeat
// while one peels a front below the minimum classified. Results then leave in index order.
// Reset is synchronous and active low; it empties the population and restores the registers.

module nondominated_front_sort
    import nfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_wdata
);

    t_obj_vec r_obj_mem [MAX_POPULATION];
    logic [IDX_W-1:0] r_rank_mem [MAX_POPULATION];

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_size, n_size;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_distinct, n_distinct;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic r_first, n_first;
    logic r_grew, n_grew;
    logic r_blocked, n_blocked;
    logic r_eq, n_eq;
    logic [MAX_POPULATION-1:0] r_valid, n_valid;
    logic [2:0] r_num_obj;
    logic [3:0] r_max_mask;
    logic [6:0] r_min_cls;

    t_obj_vec r_obj_a, r_obj_b;
    logic [IDX_W-1:0] r_rank_rd;
    logic [IDX_W-1:0] rank_addr;
    logic obj_we, rank_we;
    logic [IDX_W-1:0] rank_wdata;
    logic [2:0] nobj;
    t_rel rel;
    logic i_last, j_last;
    t_obj_vec in_vec;

    assign in_vec = {i_data.obj_3, i_data.obj_2, i_data.obj_1, i_data.obj_0};
    assign nobj = (r_num_obj == 3'd0) ? 3'd1 :
                  (r_num_obj > 3'(MAX_OBJECTIVES)) ? 3'(MAX_OBJECTIVES) : r_num_obj;
    assign rel = dominance(r_obj_a, r_obj_b, nobj, r_max_mask);
    assign i_last = ({1'b0, r_i} == (r_size - CNT_W'(1)));
    assign j_last = ({1'b0, r_j} == (r_size - CNT_W'(1)));
    assign rank_addr = (r_state == S_ORD) ? r_i : r_i;
    assign rank_wdata = r_first ? '0 : r_cur + IDX_W'(1);

    assign o_stall = (r_state != S_LOAD);
    assign o_valid = (r_state == S_OUT);
    always_comb begin
        o_data.individual_index   = r_i;
        o_data.classified         = r_valid[r_i];
        o_data.front_number       = r_valid[r_i] ? r_rank_rd : '0;
        o_data.distinct_in_front0 = i_last ? r_distinct : '0;
        o_data.last_result        = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (obj_we) begin
            r_obj_mem[r_size[IDX_W-1:0]] <= in_vec;
        end
        if (r_state == S_ISSUE) begin
            r_obj_a <= r_obj_mem[r_i];
            r_obj_b <= r_obj_mem[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_rank_mem[r_j] <= rank_wdata;
        end
        if ((r_state == S_ISSUE) || (r_state == S_ORD)) begin
            r_rank_rd <= r_rank_mem[rank_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_obj  <= 3'd2;
            r_max_mask <= 4'd0;
            r_min_cls  <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_OBJECTIVES: r_num_obj  <= i_cfg_wdata[2:0];
                CFG_MAXIMIZE_MASK:  r_max_mask <= i_cfg_wdata[3:0];
                CFG_MIN_CLASSIFIED: r_min_cls  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_size     <= '0;
            r_total    <= '0;
            r_distinct <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_cur      <= '0;
            r_first    <= 1'b0;
            r_grew     <= 1'b0;
            r_blocked  <= 1'b0;
            r_eq       <= 1'b0;
            r_valid    <= '0;
        end else begin
            r_state    <= n_state;
            r_size     <= n_size;
            r_total    <= n_total;
            r_distinct <= n_distinct;
            r_i        <= n_i;
            r_j        <= n_j;
            r_cur      <= n_cur;
            r_first    <= n_first;
            r_grew     <= n_grew;
            r_blocked  <= n_blocked;
            r_eq       <= n_eq;
            r_valid    <= n_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_total    = r_total;
        n_distinct = r_distinct;
        n_i        = r_i;
        n_j        = r_j;
        n_cur      = r_cur;
        n_first    = r_first;
        n_grew     = r_grew;
        n_blocked  = r_blocked;
        n_eq       = r_eq;
        n_valid    = r_valid;
        obj_we     = 1'b0;
        rank_we    = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_size < CNT_W'(MAX_POPULATION)) begin
                        obj_we = 1'b1;
                        n_size = r_size + CNT_W'(1);
                    end
                    if (i_data.last_item) begin
                        n_state    = S_JSTART;
                        n_j        = '0;
                        n_cur      = '0;
                        n_first    = 1'b1;
                        n_grew     = 1'b0;
                        n_total    = '0;
                        n_distinct = '0;
                    end
                end
            end
            S_JSTART: begin
                n_i  = '0;
                n_eq = 1'b0;
                if (!r_first && r_valid[r_j]) begin
                    n_blocked = 1'b1;
                    n_state   = S_JEND;
                end else begin
                    n_blocked = 1'b0;
                    n_state   = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if ((rel == REL_A_DOM) &&
                    (r_first || !(r_valid[r_i] && (r_rank_rd <= r_cur)))) begin
                    n_blocked = 1'b1;
                end
                if (r_first && (rel == REL_EQUAL) && (r_i < r_j)) begin
                    n_eq = 1'b1;
                end
                if (i_last) begin
                    n_state = S_JEND;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_ISSUE;
                end
            end
            S_JEND: begin
                if (!r_blocked) begin
                    n_valid[r_j] = 1'b1;
                    rank_we      = 1'b1;
                    n_total      = r_total + CNT_W'(1);
                    n_grew       = 1'b1;
                    if (r_first && !r_eq) begin
                        n_distinct = r_distinct + CNT_W'(1);
                    end
                end
                if (j_last) begin
                    n_state = S_PASSEND;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_JSTART;
                end
            end
            S_PASSEND: begin
                if (r_grew && (r_total < r_min_cls)) begin
                    if (!r_first) begin
                        n_cur = r_cur + IDX_W'(1);
                    end
                    n_first = 1'b0;
                    n_grew  = 1'b0;
                    n_j     = '0;
                    n_state = S_JSTART;
                end else begin
                    n_i     = '0;
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (i_last) begin
                        n_state = S_LOAD;
                        n_size  = '0;
                        n_valid = '0;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `NFS_ASSERT_NOW(a_out_in_range, i_clk, i_rst_n, o_valid, {1'b0, r_i} < r_size)
    `NFS_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, r_state != S_LOAD, r_total <= r_size)
    `NFS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, o_valid && !i_stall && o_data.last_result, (r_state == S_LOAD) && (r_size == '0) && (r_valid == '0))
    `NFS_ASSERT_NOW(a_eval_in_range, i_clk, i_rst_n, r_state == S_EVAL, ({1'b0, r_i} < r_size) && ({1'b0, r_j} < r_size))

endmodule
